/* design/slta_pkg.sv */
// Shared constants, types and helper functions for the slot table allocator.
// Used by the channel interfaces, the free-slot search and the top level.
// Depends on nothing.
`default_nettype none

package slta_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int ACTION_W    = 2;
   localparam int SLOT_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int HINT_W      = 8;

   // The free-slot search encodes the occupancy map in groups of this many slots.
   localparam int GROUP_W     = 16;
   localparam int GROUP_IDX_W = 4;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   // Result of encoding one group: whether a candidate exists and the lowest one.
   typedef struct packed {
      logic                   hit;
      logic [GROUP_IDX_W-1:0] off;
   } group_hit_type;

   // Lowest set bit of one group of candidate flags.
   function automatic group_hit_type first_free(input logic [GROUP_W-1:0] bits);
      group_hit_type res;
      res.hit = 1'b0;
      res.off = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            res.hit = 1'b1;
            res.off = GROUP_IDX_W'(i);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* design/slta_channels.sv */
// Valid/ready channel interfaces for the request and response transactions.
// Depends on slta_pkg for the field widths.
`default_nettype none

interface slta_req_if;
   import slta_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   slot;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, action, slot, value, input ready);
   modport sink   (input valid, action, slot, value, output ready);
endinterface

interface slta_rsp_if;
   import slta_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  slot_out;
   logic [VALUE_W-1:0]  read_value;
   logic [COUNT_W-1:0]  size_out;
   logic [COUNT_W-1:0]  used_out;

   modport source (output valid, status, slot_out, read_value, size_out, used_out,
                   input ready);
   modport sink   (input valid, status, slot_out, read_value, size_out, used_out,
                   output ready);
endinterface

`default_nettype wire

/* design/slot_table_allocator.sv */
// Top level of the slot table allocator: control, state registers, value memory.
// Depends on slta_pkg, the channel interfaces in slta_channels and slta_search.
`default_nettype none

// Slot table allocator. Each request transaction appends a nonzero value to the
// first empty slot (searching from the free hint up to the size, then wrapping
// from slot 0, else at the size), sets or clears one slot, or reads one slot,
// and produces exactly one response transaction carrying the status, the slot
// used, the value read and the size and used count after the request. A request
// is accepted in the idle state; in the scan state the occupancy map is encoded
// into registered per-group results while the value memory is read, and in the
// execute state the free-slot choice is made and the memory and state are
// written back. Only one request is in flight at a time; a new request is accepted as
// soon as the previous one has reached the response register, and the
// write-back cycle waits while an earlier response is still not taken. The
// occupancy map lives in flip-flops cleared by reset and gates every value
// read, so the value memory needs no clearing pass after reset.
module slot_table_allocator #(
   parameter int CAPACITY   = 256,
   parameter int VALUE_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   slta_req_if.sink   req_chan,
   slta_rsp_if.source rsp_chan
);
   import slta_pkg::*;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int SIZE_W = $clog2(CAPACITY + 1);
   localparam int KEEP_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int CMP_W  = (SIZE_W > SLOT_W) ? SIZE_W : SLOT_W;
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SIZE_W-1:0]   used_ff, used_in;
   logic [HINT_W-1:0]   hint_ff, hint_in;
   logic [CAPACITY-1:0] occ_ff, occ_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [ACTION_W-1:0] req_action_ff;
   logic [SLOT_W-1:0]   req_slot_ff;
   logic [KEEP_W-1:0]   req_value_ff;

   logic [KEEP_W-1:0]   slot_mem [CAPACITY];
   logic [KEEP_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_slot_ff;
   logic [VALUE_W-1:0]  rsp_read_ff;
   logic [COUNT_W-1:0]  rsp_size_ff;
   logic [COUNT_W-1:0]  rsp_used_ff;

   logic                req_take;
   logic                commit;
   logic                val_nz;
   logic                slot_ok;
   logic [IDX_W-1:0]    slot_idx;
   logic                slot_occ;
   logic                found;
   logic [SIZE_W-1:0]   found_idx;
   logic [STATUS_W-1:0] res_status;
   logic [SIZE_W-1:0]   res_slot;
   logic [KEEP_W-1:0]   res_read;

   // Free-slot search over the current occupancy map.
   slta_search #(
      .CAPACITY (CAPACITY)
   ) u_search (
      .clock     (clock),
      .occupied  (occ_ff),
      .size      (size_ff),
      .hint      (hint_ff),
      .found     (found),
      .found_idx (found_idx)
   );

   // Handshake and decode of the held request.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && (state_ff == S_IDLE);
   assign commit         = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign val_nz         = |req_value_ff;
   assign slot_ok        = CMP_W'(req_slot_ff) < CMP_W'(size_ff);
   assign slot_idx       = IDX_W'(req_slot_ff);
   assign slot_occ       = occ_ff[slot_idx];

   // Request capture; only the kept value bits are stored.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= req_chan.action;
         req_slot_ff   <= req_chan.slot;
         req_value_ff  <= req_chan.value[KEEP_W-1:0];
      end
   end

   // Value memory: one read port used by get, one write port used at commit.
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[slot_idx];
      if (mem_we) begin
         slot_mem[mem_waddr] <= req_value_ff;
      end
   end

   // Read-modify-write of the table state in the commit cycle.
   always_comb begin
      size_in    = size_ff;
      used_in    = used_ff;
      hint_in    = hint_ff;
      occ_in     = occ_ff;
      mem_we     = 1'b0;
      mem_waddr  = slot_idx;
      res_status = STAT_OK;
      res_slot   = '0;
      res_read   = '0;
      if (commit) begin
         case (req_action_ff)
            ACT_APPEND: begin
               if (!val_nz) begin
                  res_slot = size_ff;
               end else if (found) begin
                  mem_we                    = 1'b1;
                  mem_waddr                 = IDX_W'(found_idx);
                  occ_in[IDX_W'(found_idx)] = 1'b1;
                  used_in                   = used_ff + SIZE_W'(1);
                  res_slot                  = found_idx;
               end else if (size_ff != SIZE_MAX) begin
                  mem_we                  = 1'b1;
                  mem_waddr               = IDX_W'(size_ff);
                  occ_in[IDX_W'(size_ff)] = 1'b1;
                  size_in                 = size_ff + SIZE_W'(1);
                  used_in                 = used_ff + SIZE_W'(1);
                  res_slot                = size_ff;
               end else begin
                  res_status = STAT_FULL;
               end
            end
            ACT_SET: begin
               if (!slot_ok) begin
                  res_status = STAT_RANGE;
               end else begin
                  mem_we           = 1'b1;
                  occ_in[slot_idx] = val_nz;
                  if (slot_occ && !val_nz) begin
                     used_in = used_ff - SIZE_W'(1);
                  end else if (!slot_occ && val_nz) begin
                     used_in = used_ff + SIZE_W'(1);
                  end
                  // Clearing the top slot shrinks the table; any other clear
                  // points the hint at the new hole.
                  if (!val_nz) begin
                     if (CMP_W'(req_slot_ff) == CMP_W'(size_ff) - CMP_W'(1)) begin
                        size_in = SIZE_W'(req_slot_ff);
                     end else begin
                        hint_in = req_slot_ff;
                     end
                  end
               end
            end
            ACT_GET: begin
               if (!slot_ok) begin
                  res_status = STAT_RANGE;
               end else if (slot_occ) begin
                  res_read = rd_data_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: accept, scan and read, then commit once the response register is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register valid: set at commit, dropped when the transaction is taken.
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and table state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         size_ff      <= '0;
         used_ff      <= '0;
         hint_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         used_ff      <= used_in;
         hint_ff      <= hint_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= COUNT_W'(res_slot);
         rsp_read_ff   <= VALUE_W'(res_read);
         rsp_size_ff   <= COUNT_W'(size_in);
         rsp_used_ff   <= COUNT_W'(used_in);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_out   = rsp_slot_ff;
   assign rsp_chan.read_value = rsp_read_ff;
   assign rsp_chan.size_out   = rsp_size_ff;
   assign rsp_chan.used_out   = rsp_used_ff;

`ifndef SYNTHESIS
   // The used count always matches the number of occupied slots.
   a_used_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == int'(used_ff))
      else $error("used count differs from occupancy map");

   // Every occupied slot lies below the size, so used never exceeds size.
   a_used_le_size: assert property (@(posedge clock) disable iff (reset)
      used_ff <= size_ff)
      else $error("used count exceeds size");

   // The size never grows past the capacity.
   a_size_le_cap: assert property (@(posedge clock) disable iff (reset)
      int'(size_ff) <= CAPACITY)
      else $error("size exceeds capacity");

   // A response appears only out of the commit cycle.
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("response raised outside commit");

   // State only changes at a commit.
   a_state_at_commit: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(size_ff) && $stable(used_ff) && $stable(hint_ff))
      else $error("table state changed without commit");
`endif

endmodule

`default_nettype wire

/* design/slta_search.sv */
// Free-slot search: a two-stage rotating priority encoder over the occupancy map.
// Stage one registers a per-group encode, stage two picks the first group.
// Depends on slta_pkg.
`default_nettype none

module slta_search #(
   parameter int CAPACITY = 256
) (
   input  wire logic                             clock,
   input  wire logic [CAPACITY-1:0]              occupied,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    size,
   input  wire logic [slta_pkg::HINT_W-1:0]      hint,
   output logic                                  found,
   output logic [$clog2(CAPACITY+1)-1:0]         found_idx
);
   import slta_pkg::*;

   localparam int SIZE_W  = $clog2(CAPACITY + 1);
   localparam int GROUP_N = (CAPACITY + GROUP_W - 1) / GROUP_W;
   localparam int SCAN_N  = GROUP_N * GROUP_W;
   localparam int POS_W   = $clog2(SCAN_N);

   logic [SCAN_N-1:0] occ_pad;
   logic [SCAN_N-1:0] hi_mask;
   logic [SCAN_N-1:0] lo_mask;
   group_hit_type     hi_grp_ff [GROUP_N];
   group_hit_type     lo_grp_ff [GROUP_N];
   logic              hi_hit;
   logic              lo_hit;
   logic [POS_W-1:0]  hi_pos;
   logic [POS_W-1:0]  lo_pos;

   // Padding slots lie at or above the size, so they never become candidates.
   assign occ_pad = SCAN_N'(occupied);

   // Candidates: empty slots below the size, split at the hint into the
   // first pass (hint and up) and the wrap pass (below the hint).
   always_comb begin
      for (int i = 0; i < SCAN_N; i++) begin
         hi_mask[i] = !occ_pad[i] && (i < int'(size)) && (i >= int'(hint));
         lo_mask[i] = !occ_pad[i] && (i < int'(size)) && (i < int'(hint));
      end
   end

   // Stage one: encode every group and register the results.
   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUP_N; g++) begin
         hi_grp_ff[g] <= first_free(hi_mask[g*GROUP_W +: GROUP_W]);
         lo_grp_ff[g] <= first_free(lo_mask[g*GROUP_W +: GROUP_W]);
      end
   end

   // Stage two: lowest group with a hit, first pass taking priority over the wrap.
   always_comb begin
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_pos = '0;
      lo_pos = '0;
      for (int g = GROUP_N - 1; g >= 0; g--) begin
         if (hi_grp_ff[g].hit) begin
            hi_hit = 1'b1;
            hi_pos = POS_W'(g * GROUP_W) + POS_W'(hi_grp_ff[g].off);
         end
         if (lo_grp_ff[g].hit) begin
            lo_hit = 1'b1;
            lo_pos = POS_W'(g * GROUP_W) + POS_W'(lo_grp_ff[g].off);
         end
      end
      found     = hi_hit || lo_hit;
      found_idx = hi_hit ? SIZE_W'(hi_pos) : SIZE_W'(lo_pos);
   end

endmodule

`default_nettype wire
